// ===== hdl/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted array engine package
// Shared widths, codes and types of the ordered value store.
// ----------------------------------------------------------------------------
package sae_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int VAL_W         = 64;
  localparam int OP_W          = 3;
  localparam int IDX_W         = 8;
  localparam int STAT_W        = 2;
  localparam int CNT_W         = 9;

  typedef logic signed [VAL_W-1:0] val_t;

  // Operation codes; the codes above reverse are unused and do nothing.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_APPEND  = 3'd1,
    OP_PREPEND = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REVERSE = 3'd4
  } op_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_TAIL,
    S_FLUSH,
    S_DONE
  } state_t;

  // Controls of the order tracker.
  typedef struct packed {
    logic clear;
    logic swap;
    logic valid;
  } ord_ctl_t;

endpackage

// ===== hdl/sae_if.sv =====
// ----------------------------------------------------------------------------
// Sorted array engine channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface sae_in_if;
  logic                          valid;
  logic                          ready;
  logic [sae_pkg::OP_W-1:0]      op;
  logic signed [sae_pkg::VAL_W-1:0] value;
  logic [sae_pkg::IDX_W-1:0]     index;

  modport source (output valid, op, value, index, input ready);
  modport sink   (input valid, op, value, index, output ready);
endinterface

interface sae_out_if;
  logic                        valid;
  logic                        ready;
  logic [sae_pkg::STAT_W-1:0]  status;
  logic [sae_pkg::CNT_W-1:0]   count;
  logic                        ascending;
  logic                        descending;

  modport source (output valid, status, count, ascending, descending, input ready);
  modport sink   (input valid, status, count, ascending, descending, output ready);
endinterface

// ===== hdl/sae_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted array engine entry memory
// One write port and one registered read port; a read and a write of the
// same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module sae_ram #(
  parameter int DEPTH = sae_pkg::DEPTH_DEFAULT,
  parameter int W     = sae_pkg::VAL_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sae_order.sv =====
// ----------------------------------------------------------------------------
// Sorted array engine order tracker
// Follows the stream of final entries and keeps the two order flags.
// ----------------------------------------------------------------------------
module sae_order (
  input  logic              clk,
  input  logic              rst_n,
  input  sae_pkg::ord_ctl_t ctl,
  input  sae_pkg::val_t     val,
  output logic              asc,
  output logic              desc
);

  logic          have_r;
  sae_pkg::val_t prev_r;
  logic          asc_r;
  logic          desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      asc_r  <= 1'b1;
      desc_r <= 1'b1;
    end else begin
      priority if (ctl.clear) begin
        have_r <= 1'b0;
        asc_r  <= 1'b1;
        desc_r <= 1'b1;
      end else if (ctl.swap) begin
        // A reversed array is ascending exactly when it was descending.
        asc_r  <= desc_r;
        desc_r <= asc_r;
      end else if (ctl.valid) begin
        have_r <= 1'b1;
        if (have_r && (val < prev_r)) begin
          asc_r <= 1'b0;
        end
        if (have_r && (prev_r < val)) begin
          desc_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prev_r <= val;
    end
  end

  assign asc  = asc_r;
  assign desc = desc_r;

endmodule

// ===== hdl/sorted_array_engine_top.sv =====
// ----------------------------------------------------------------------------
// Sorted array engine
// Ordered store of signed 64-bit values with insert, append, prepend,
// remove and reverse, reporting status, count and order flags per item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                  Handshake
//   in_ch    in         op, value, index                         valid/ready
//   out_ch   out        status, count, ascending, descending     valid/ready
//
// Insert, append and prepend pass over the N entries held and then go through
// the tail and flush states; remove and reverse pass and then flush; an item
// that is rejected, unused or a reverse of one entry or none goes straight to
// done. Each entry is read at most once, through the single read port.
// Reset clears the count and order flags; the memory is never cleared, as only
// entries below the count are read. A new item is taken while the previous
// result still waits, and its own result then waits for the output register.
//
module sorted_array_engine_top #(
  parameter int DEPTH = sae_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  sae_in_if.sink           in_ch,
  sae_out_if.source        out_ch
);

  // Address width of the memory and width of the count, which must reach
  // DEPTH itself. The result channel carries the count at the package width.
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IDX_W = sae_pkg::IDX_W;
  localparam int CNT_W = sae_pkg::CNT_W;
  localparam int XW    = (CW > IDX_W) ? CW : IDX_W;

  sae_pkg::state_t  state_r;
  sae_pkg::state_t  state_nxt;

  // Latched item.
  logic [sae_pkg::OP_W-1:0] op_r;
  sae_pkg::val_t            val_r;
  logic [IDX_W-1:0]         idx_r;
  sae_pkg::status_t         status_r;

  logic [CW-1:0] fill_r;

  // Scan position; for reverse j_r is the low pointer and hi_r the high one.
  logic [CW-1:0] j_r;
  logic [AW-1:0] hi_r;
  logic          phase_r;

  // Insert bookkeeping: found_r is set once the new value has gone in, and
  // carry_r holds the entry displaced one place up.
  logic          found_r;
  sae_pkg::val_t carry_r;

  // Read pipeline tags: which address the returning data came from and,
  // for reverse, the address it is written to.
  logic          rvalid_r;
  logic [AW-1:0] rj_r;
  logic [AW-1:0] rpart_r;

  // Stream of final entries towards the order tracker.
  logic          st_valid_r;
  sae_pkg::val_t st_data_r;

  // Output register.
  logic                     out_valid_r;
  logic [sae_pkg::STAT_W-1:0] out_status_r;
  logic [CW-1:0]            out_count_r;
  logic                     out_asc_r;
  logic                     out_desc_r;

  // Combinational controls.
  logic             in_fire;
  logic             acc_run;
  sae_pkg::status_t acc_status;
  logic             op_ins;
  logic             op_rev;
  logic             op_rem;
  logic             run_done;
  logic             issue;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    rpart;
  logic             out_load;
  logic             in_ready;

  sae_pkg::val_t    rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  sae_pkg::val_t    wdata;
  logic             emit;
  sae_pkg::val_t    emit_val;
  logic             take;

  sae_pkg::ord_ctl_t ord_ctl;
  logic              asc;
  logic              desc;

  logic [XW-1:0]    idx_x;
  logic [XW-1:0]    fill_x;
  logic [XW-1:0]    rj_x;
  logic [XW-1:0]    idxr_x;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign op_ins  = (op_r == sae_pkg::OP_INSERT) || (op_r == sae_pkg::OP_APPEND) ||
                   (op_r == sae_pkg::OP_PREPEND);
  assign op_rem  = (op_r == sae_pkg::OP_REMOVE);
  assign op_rev  = (op_r == sae_pkg::OP_REVERSE);

  assign idx_x   = XW'(in_ch.index);
  assign fill_x  = XW'(fill_r);
  assign rj_x    = XW'(rj_r);
  assign idxr_x  = XW'(idx_r);

  // Decide at acceptance whether the item needs a pass over the memory.
  always_comb begin
    acc_status = sae_pkg::STAT_DONE;
    acc_run    = 1'b0;
    unique case (in_ch.op)
      sae_pkg::OP_INSERT, sae_pkg::OP_APPEND, sae_pkg::OP_PREPEND: begin
        if (fill_r == CW'(DEPTH)) begin
          acc_status = sae_pkg::STAT_FULL;
        end else begin
          acc_run = 1'b1;
        end
      end
      sae_pkg::OP_REMOVE: begin
        if (idx_x >= fill_x) begin
          acc_status = sae_pkg::STAT_RANGE;
        end else begin
          acc_run = 1'b1;
        end
      end
      sae_pkg::OP_REVERSE: begin
        acc_run = (fill_r > CW'(1));
      end
      default: begin
        acc_status = sae_pkg::STAT_DONE;
      end
    endcase
  end

  // The pass ends once every stored entry has been read, or for reverse
  // once the two pointers meet.
  always_comb begin
    if (op_rev) begin
      run_done = !(j_r < CW'(hi_r));
    end else begin
      run_done = (j_r == fill_r);
    end
    raddr = (op_rev && phase_r) ? hi_r : j_r[AW-1:0];
    rpart = phase_r ? j_r[AW-1:0] : hi_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sae_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = acc_run ? sae_pkg::S_RUN : sae_pkg::S_DONE;
        end
      end
      sae_pkg::S_RUN: begin
        if (run_done) begin
          state_nxt = op_ins ? sae_pkg::S_TAIL : sae_pkg::S_FLUSH;
        end
      end
      sae_pkg::S_TAIL: begin
        state_nxt = sae_pkg::S_FLUSH;
      end
      sae_pkg::S_FLUSH: begin
        state_nxt = sae_pkg::S_DONE;
      end
      sae_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = sae_pkg::S_IDLE;
        end
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = (state_r == sae_pkg::S_IDLE);
    issue    = (state_r == sae_pkg::S_RUN) && !run_done;
    out_load = (state_r == sae_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  end

  // Data path of the pass. Insert walks forward: entries before the slot
  // stay, the new value lands in the slot, and every later entry moves up
  // one place through carry_r. Remove moves every entry above the index down
  // one place. Reverse writes each read entry to its mirror address. The
  // write always trails the read by at least one address, so no entry is
  // read and written in the same cycle except the mirror case, where the
  // memory returns the old contents.
  always_comb begin
    we       = 1'b0;
    waddr    = rj_r;
    wdata    = rdata;
    emit     = 1'b0;
    emit_val = rdata;
    take     = 1'b0;
    if (state_r == sae_pkg::S_TAIL) begin
      we       = 1'b1;
      waddr    = fill_r[AW-1:0];
      wdata    = found_r ? carry_r : val_r;
      emit     = 1'b1;
      emit_val = wdata;
    end else if (rvalid_r) begin
      if (op_ins) begin
        take = found_r || (op_r == sae_pkg::OP_PREPEND) ||
               ((op_r == sae_pkg::OP_INSERT) && !(rdata < val_r));
        we       = take;
        waddr    = rj_r;
        wdata    = found_r ? carry_r : val_r;
        emit     = 1'b1;
        emit_val = take ? wdata : rdata;
      end else if (op_rem) begin
        we       = (rj_x > idxr_x);
        waddr    = rj_r - AW'(1);
        wdata    = rdata;
        emit     = (rj_x != idxr_x);
        emit_val = rdata;
      end else begin
        we    = 1'b1;
        waddr = rpart_r;
        wdata = rdata;
      end
    end
  end

  assign ord_ctl.clear = in_fire && acc_run && (in_ch.op != sae_pkg::OP_REVERSE);
  assign ord_ctl.swap  = in_fire && (in_ch.op == sae_pkg::OP_REVERSE);
  assign ord_ctl.valid = st_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sae_pkg::S_IDLE;
      fill_r      <= '0;
      rvalid_r    <= 1'b0;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rvalid_r   <= issue;
      st_valid_r <= emit;
      if (in_fire) begin
        found_r <= 1'b0;
      end else if (rvalid_r && op_ins && take) begin
        found_r <= 1'b1;
      end
      if (state_r == sae_pkg::S_FLUSH) begin
        if (op_ins) begin
          fill_r <= fill_r + CW'(1);
        end else if (op_rem) begin
          fill_r <= fill_r - CW'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and pointer registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_ch.op;
      val_r    <= in_ch.value;
      idx_r    <= in_ch.index;
      status_r <= acc_status;
      j_r      <= '0;
      hi_r     <= AW'(fill_r - CW'(1));
      phase_r  <= 1'b0;
    end else if (issue) begin
      if (!op_rev) begin
        j_r <= j_r + CW'(1);
      end else begin
        phase_r <= !phase_r;
        if (phase_r) begin
          j_r  <= j_r + CW'(1);
          hi_r <= hi_r - AW'(1);
        end
      end
    end
    if (issue) begin
      rj_r    <= raddr;
      rpart_r <= rpart;
    end
    if (rvalid_r && op_ins && take) begin
      carry_r <= rdata;
    end
    if (emit) begin
      st_data_r <= emit_val;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= fill_r;
      out_asc_r    <= asc;
      out_desc_r   <= desc;
    end
  end

  sae_ram #(
    .DEPTH (DEPTH),
    .W     (sae_pkg::VAL_W),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  sae_order u_order (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ord_ctl),
    .val   (st_data_r),
    .asc   (asc),
    .desc  (desc)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = CNT_W'(out_count_r);
  assign out_ch.ascending  = out_asc_r;
  assign out_ch.descending = out_desc_r;

  // The count never passes the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count exceeds capacity");

  // Writes stay within the held entries plus the one being added.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CW'(waddr) <= fill_r))
    else $error("memory write beyond the held entries");

  // Read data only returns while a pass is under way.
  a_read_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> ((state_r == sae_pkg::S_RUN) || (state_r == sae_pkg::S_FLUSH) ||
                  (state_r == sae_pkg::S_TAIL)))
    else $error("read data outside a pass");

  // An empty store is always in both orders when idle.
  a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == sae_pkg::S_IDLE) && (fill_r == '0)) |-> (asc && desc))
    else $error("empty store reports an order violation");

  // A finished result is handed to the output register and the block idles.
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == sae_pkg::S_IDLE)))
    else $error("result not loaded on completion");

endmodule
